// ----- hw/rtl/isu_pkg.sv -----
// Package for the Ising spin-update core: lattice size, field widths,
// controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package isu_pkg;

    // Lattice geometry
    localparam int SIDE   = 64;
    localparam int LAT_AW = $clog2(SIDE);
    localparam int CLR_W  = $clog2(SIDE + 1);

    // Field widths
    localparam int COORD_W  = 6;
    localparam int DRAW_W   = 16;
    localparam int THR_W    = 17;
    localparam int DELTA_W  = 5;
    localparam int ENERGY_W = 15;
    localparam int MAGNET_W = 14;
    localparam int FLIPS_W  = 32;

    localparam int IN_W  = 32;
    localparam int OUT_W = 72;

    // Reset values
    localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-(2 * SIDE * SIDE));
    localparam logic [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(SIDE * SIDE);
    localparam logic [THR_W-1:0]    THR_FOUR_RESET  = THR_W'(1200);
    localparam logic [THR_W-1:0]    THR_EIGHT_RESET = THR_W'(22);

    // Configuration register indexes
    localparam logic CFG_THR_FOUR  = 1'b0;
    localparam logic CFG_THR_EIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_NBR,
        ST_READ_ROW,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clr_we;
        logic load;
        logic rd_nbr;
        logic rd_row;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/isu_ram.sv -----
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module isu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic                     re_b,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/isu_ctrl.sv -----
// Controller for the spin-update core: clearing pass, read sequence, update.
// Depends on isu_pkg.
`default_nettype none

module isu_ctrl
    import isu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ_NBR;
                end
            end
            ST_READ_NBR: state_next = ST_READ_ROW;
            ST_READ_ROW: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = !status.clr_done;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ_NBR:
            begin
                cmd.rd_nbr = 1'b1;
            end
            ST_READ_ROW:
            begin
                cmd.rd_row = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/isu_dp.sv -----
// Datapath for the spin-update core: lattice RAM (one row per word),
// neighbor evaluation, Metropolis test, running totals, output register.
// Depends on isu_pkg and isu_ram.
`default_nettype none

module isu_dp
    import isu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output status_t               status,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic      [OUT_W-1:0] m_tdata,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_index,
    input  wire logic [THR_W-1:0] cfg_data
);

    // Trial registers
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic               up_bit_reg;

    // Config and totals
    logic [THR_W-1:0]    thr_four_reg;
    logic [THR_W-1:0]    thr_eight_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic [MAGNET_W-1:0] magnet_reg;
    logic [MAGNET_W-1:0] magnet_next;
    logic [FLIPS_W-1:0]  flips_reg;
    logic [CLR_W-1:0]    clr_cnt_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // Lattice RAM ports
    logic              ram_we;
    logic [LAT_AW-1:0] ram_waddr;
    logic [SIDE-1:0]   ram_wdata;
    logic              ram_re_a;
    logic [LAT_AW-1:0] ram_raddr_a;
    logic [SIDE-1:0]   ram_rdata_a;
    logic [SIDE-1:0]   ram_rdata_b;

    logic [LAT_AW-1:0] xi;
    logic [LAT_AW-1:0] yi;
    logic [LAT_AW-1:0] xl;
    logic [LAT_AW-1:0] xr;
    logic [LAT_AW-1:0] yu;
    logic [LAT_AW-1:0] yd;
    logic              spin;
    logic [3:0]        nbr;
    logic [3:0]        match;
    logic [2:0]        match_cnt;
    logic              oor;
    logic              flip;
    logic [DELTA_W-1:0] delta;
    logic [SIDE-1:0]   row_flipped;

    assign xi = x_reg[LAT_AW-1:0];
    assign yi = y_reg[LAT_AW-1:0];
    assign xl = (xi == '0) ? LAT_AW'(SIDE - 1) : xi - 1'b1;
    assign xr = (xi == LAT_AW'(SIDE - 1)) ? '0 : xi + 1'b1;
    assign yu = (yi == '0) ? LAT_AW'(SIDE - 1) : yi - 1'b1;
    assign yd = (yi == LAT_AW'(SIDE - 1)) ? '0 : yi + 1'b1;

    assign oor = (32'(x_reg) >= SIDE) || (32'(y_reg) >= SIDE);

    // In the update cycle port a holds row y, port b still holds row y+1
    assign spin  = ram_rdata_a[xi];
    assign nbr   = {ram_rdata_a[xl], ram_rdata_a[xr], up_bit_reg, ram_rdata_b[xi]};
    assign match = ~(nbr ^ {4{spin}});
    assign match_cnt = 3'(match[0]) + 3'(match[1]) + 3'(match[2]) + 3'(match[3]);

    // deltaE = 4*(neighbors equal to the spin) - 8
    assign delta = oor ? '0 : ({match_cnt, 2'b00} - DELTA_W'(8));

    always_comb
    begin
        flip = 1'b0;
        if (!oor)
        begin
            if (match_cnt <= 3'd2)
            begin
                flip = 1'b1;
            end
            else if (match_cnt == 3'd3)
            begin
                flip = {1'b0, draw_reg} <= thr_four_reg;
            end
            else
            begin
                flip = {1'b0, draw_reg} <= thr_eight_reg;
            end
        end
    end

    always_comb
    begin
        row_flipped     = ram_rdata_a;
        row_flipped[xi] = !spin;
    end

    assign energy_next = flip ? energy_reg + {{(ENERGY_W-DELTA_W){delta[DELTA_W-1]}}, delta}
                              : energy_reg;
    assign magnet_next = !flip ? magnet_reg
                       : (spin ? magnet_reg - MAGNET_W'(2) : magnet_reg + MAGNET_W'(2));

    assign ram_we      = cmd.clr_we || (cmd.update && flip);
    assign ram_waddr   = cmd.clr_we ? clr_cnt_reg[LAT_AW-1:0] : yi;
    assign ram_wdata   = cmd.clr_we ? '1 : row_flipped;
    assign ram_re_a    = cmd.rd_nbr || cmd.rd_row;
    assign ram_raddr_a = cmd.rd_row ? yi : yu;

    isu_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_lattice (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (cmd.rd_nbr),
        .raddr_b (yd),
        .rdata_b (ram_rdata_b)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= s_tdata[COORD_W-1:0];
            y_reg    <= s_tdata[2*COORD_W-1:COORD_W];
            draw_reg <= s_tdata[2*COORD_W+DRAW_W-1:2*COORD_W];
        end
        if (cmd.rd_row)
        begin
            up_bit_reg <= ram_rdata_a[xi];
        end
        if (cmd.update)
        begin
            out_data_reg <= {4'b0000, flips_reg + FLIPS_W'(flip), magnet_next, energy_next,
                             delta, oor, flip};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_four_reg  <= THR_FOUR_RESET;
            thr_eight_reg <= THR_EIGHT_RESET;
            energy_reg    <= ENERGY_RESET;
            magnet_reg    <= MAGNET_RESET;
            flips_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_THR_FOUR)
                begin
                    thr_four_reg <= cfg_data;
                end
                else
                begin
                    thr_eight_reg <= cfg_data;
                end
            end
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                energy_reg <= energy_next;
                magnet_reg <= magnet_next;
                flips_reg  <= flips_reg + FLIPS_W'(flip);
            end
            out_valid_reg <= cmd.update || (out_valid_reg && !m_tready);
        end
    end

    assign status.clr_done = (clr_cnt_reg == CLR_W'(SIDE));
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ising_metropolis_spin_update_core.sv -----
// Top level of the 2-D Ising Metropolis spin-update core.
// Depends on isu_pkg, isu_ctrl, isu_dp (which holds isu_ram).
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  s       | s_tvalid/s_tready  | s_tdata: site_x, site_y, random_draw
//  m       | m_tvalid/m_tready  | m_tdata: accepted .. flip_total
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (threshold registers)
//
// Each trial runs through four steps: transfer, read rows y-1 and y+1, read row y,
// then evaluate and write back; the lattice RAM (one row per word) sets this.
// After reset a clearing pass writes all SIDE (64) rows and sets every spin to +1;
// s_tready stays low meanwhile, configuration writes are taken.
// The result waits in an output register; a stalled m side holds the core
// in its update step only once the next trial is ready to be written.
`default_nettype none

module ising_metropolis_spin_update_core
    import isu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // [5:0] site_x, [11:6] site_y, [27:12] random_draw
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata,   // [0] accepted, [1] out_of_range,
                                             // [6:2] energy_change, [21:7] total_energy,
                                             // [35:22] total_magnetization, [67:36] flip_total
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [THR_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    isu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    isu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/isu_checker.sv -----
// Port-level checks for the spin-update core, bound to the top level.
// Depends on isu_pkg.
`default_nettype none

module isu_checker
    import isu_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One trial at a time: no transfer in the cycle after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while trial in progress");

    // A flagged site is never flipped
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("out-of-range site reported as flipped");

    // A flagged site reports no energy change
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[6:2] == '0)
        else $error("out-of-range site with nonzero energy change");

    // A move that lowers or keeps the energy is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] && (m_tdata[6] || m_tdata[6:2] == '0) |-> m_tdata[0])
        else $error("downhill move rejected");

endmodule

bind ising_metropolis_spin_update_core isu_checker u_isu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

// ----- sim/tb_ising_metropolis_spin_update_core.sv -----
// Self-checking testbench for ising_metropolis_spin_update_core: trial stream in,
// one result per trial out, threshold registers rewritten between phases.
// Depends on isu_pkg and the core RTL.

module tb_ising_metropolis_spin_update_core;
    import isu_pkg::*;

    localparam int TRIAL_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 2 * TRIAL_CYCLES;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASES        = 6;
    localparam int PHASE_TRIALS  = 165;
    localparam int DRAW_MAX      = (1 << DRAW_W) - 1;

    typedef struct packed {
        logic [COORD_W-1:0] site_x;
        logic [COORD_W-1:0] site_y;
        logic [DRAW_W-1:0]  random_draw;
    } trial_t;

    typedef struct packed {
        logic                accepted;
        logic                out_of_range;
        logic [DELTA_W-1:0]  energy_change;
        logic [ENERGY_W-1:0] total_energy;
        logic [MAGNET_W-1:0] total_magnetization;
        logic [FLIPS_W-1:0]  flip_total;
    } trial_outcome_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_THR_FOUR;
    logic [THR_W-1:0] cfg_data = '0;

    // Lattice model, 1 means spin +1
    bit                         spin_up [SIDE*SIDE];
    logic signed [ENERGY_W-1:0] energy_now;
    logic signed [MAGNET_W-1:0] magnet_now;
    logic [FLIPS_W-1:0]         flips_now;
    logic [THR_W-1:0]           thr_four_now;
    logic [THR_W-1:0]           thr_eight_now;

    trial_t         pending_trials [$];
    trial_outcome_t outcomes_due [$];

    int mismatches   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int hold_left    = 0;
    int next_hold_at = 250;

    ising_metropolis_spin_update_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int spin_of(int x, int y);
        return spin_up[y * SIDE + x] ? 1 : -1;
    endfunction

    function automatic void queue_trial(int x, int y, int draw);
        trial_t t;
        t.site_x      = COORD_W'(x);
        t.site_y      = COORD_W'(y);
        t.random_draw = DRAW_W'(draw);
        pending_trials.push_back(t);
    endfunction

    // Most sites cluster in two small windows (one across the wrap corner) so that
    // neighbors interact, the rest anywhere; draws favor edges and current thresholds.
    function automatic trial_t random_trial();
        trial_t t;
        int region;
        int base;
        int target;
        int d;
        region = $urandom_range(0, 3);
        if (region == 3)
        begin
            t.site_x = COORD_W'($urandom_range(0, SIDE - 1));
            t.site_y = COORD_W'($urandom_range(0, SIDE - 1));
        end
        else
        begin
            base = (region == 2) ? SIDE / 2 : SIDE - 3;
            t.site_x = COORD_W'((base + int'($urandom_range(0, 5))) % SIDE);
            t.site_y = COORD_W'((base + int'($urandom_range(0, 5))) % SIDE);
        end
        target = $urandom_range(0, 1) ? int'(thr_four_now) : int'(thr_eight_now);
        case ($urandom_range(0, 7))
            0:       d = 0;
            1:       d = DRAW_MAX;
            2, 3:    d = target + int'($urandom_range(0, 4)) - 2;
            default: d = $urandom_range(0, DRAW_MAX);
        endcase
        if (d < 0)
            d = 0;
        else if (d > DRAW_MAX)
            d = DRAW_MAX;
        t.random_draw = DRAW_W'(d);
        return t;
    endfunction

    task automatic write_threshold(input logic idx, input logic [THR_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_trials.size() != 0 || s_tvalid || outcomes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [FLIPS_W-1:0] got,
                               input logic [FLIPS_W-1:0] want);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, field, want, got);
            mismatches++;
        end
    endtask

    // Metropolis predictor: tracks lattice, totals and thresholds from the
    // transfers seen on the trial and configuration channels.
    always @(posedge clk)
    begin : metropolis_predictor
        int x;
        int y;
        int spin_self;
        int nbr_sum;
        int delta;
        bit take;
        trial_t t;
        trial_outcome_t outcome;
        if (!rst_n)
        begin
            foreach (spin_up[i])
                spin_up[i] = 1'b1;
            energy_now    = ENERGY_RESET;
            magnet_now    = MAGNET_RESET;
            flips_now     = '0;
            thr_four_now  = THR_FOUR_RESET;
            thr_eight_now = THR_EIGHT_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_THR_FOUR)
                    thr_four_now = cfg_data;
                else
                    thr_eight_now = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                t = trial_t'({s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W],
                              s_tdata[2*COORD_W+DRAW_W-1:2*COORD_W]});
                x = int'(t.site_x);
                y = int'(t.site_y);
                delta = 0;
                take  = 1'b0;
                // Unreachable while SIDE fills the coordinate width
                outcome.out_of_range = (x >= SIDE) || (y >= SIDE);
                if (!outcome.out_of_range)
                begin
                    spin_self = spin_of(x, y);
                    nbr_sum = spin_of((x + SIDE - 1) % SIDE, y) + spin_of((x + 1) % SIDE, y)
                            + spin_of(x, (y + SIDE - 1) % SIDE) + spin_of(x, (y + 1) % SIDE);
                    delta = 2 * spin_self * nbr_sum;
                    if (delta <= 0)
                        take = 1'b1;
                    else if (delta == 4)
                        take = {1'b0, t.random_draw} <= thr_four_now;
                    else
                        take = {1'b0, t.random_draw} <= thr_eight_now;
                    if (take)
                    begin
                        spin_up[y * SIDE + x] = (spin_self < 0);
                        magnet_now = (spin_self > 0) ? magnet_now - MAGNET_W'(2)
                                                     : magnet_now + MAGNET_W'(2);
                        energy_now = energy_now + ENERGY_W'(delta);
                        flips_now  = flips_now + FLIPS_W'(1);
                    end
                end
                outcome.accepted            = take;
                outcome.energy_change       = DELTA_W'(delta);
                outcome.total_energy        = energy_now;
                outcome.total_magnetization = magnet_now;
                outcome.flip_total          = flips_now;
                outcomes_due.push_back(outcome);
            end
        end
    end

    // Trial sender: bursts of random length separated by random gaps, sometimes none
    always @(posedge clk)
    begin : trial_sender
        trial_t next;
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_trials.size() != 0)
            begin
                next = pending_trials.pop_front();
                s_tdata  <= IN_W'({next.random_draw, next.site_y, next.site_x});
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: switches among stall patterns; every few hundred
    // results it holds off long enough to back the core up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (results_seen >= next_hold_at)
            begin
                hold_left    <= 200;
                next_hold_at <= next_hold_at + 400;
                m_tready     <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      <= $urandom_range(0, 2);
                    rx_mode_left <= $urandom_range(16, 96);
                end
                else
                    rx_mode_left <= rx_mode_left - 1;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        trial_outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcomes_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d: unexpected transfer, m_tdata 0x%0h",
                             results_seen, m_tdata);
                mismatches++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                check_field("accepted", FLIPS_W'(m_tdata[0]), FLIPS_W'(want.accepted));
                check_field("out_of_range", FLIPS_W'(m_tdata[1]),
                            FLIPS_W'(want.out_of_range));
                check_field("energy_change", FLIPS_W'(m_tdata[6:2]),
                            FLIPS_W'(want.energy_change));
                check_field("total_energy", FLIPS_W'(m_tdata[21:7]),
                            FLIPS_W'(want.total_energy));
                check_field("total_magnetization", FLIPS_W'(m_tdata[35:22]),
                            FLIPS_W'(want.total_magnetization));
                check_field("flip_total", m_tdata[67:36], want.flip_total);
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_ising_metropolis_spin_update_core failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [THR_W-1:0] four_set  [PHASES];
        logic [THR_W-1:0] eight_set [PHASES];
        // zero, exactly one, four beyond one, near Tc, random, eight beyond one
        four_set  = '{17'd0, 17'd65536, 17'd131071, 17'd11253, 17'd0, 17'd0};
        eight_set = '{17'd0, 17'd65536, 17'd0, 17'd1932, 17'd0, 17'd131071};
        four_set[4]  = THR_W'($urandom_range(0, 65536));
        eight_set[4] = THR_W'($urandom_range(0, 65536));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed trials under the reset thresholds (1200 and 22)
        queue_trial(0, 0, 0);                  // +8 from the all-up lattice, wrap corner
        queue_trial(1, 0, DRAW_MAX);           // +4 rejected
        queue_trial(1, 0, 1200);               // +4, draw equal to threshold
        queue_trial(63, 0, 0);                 // +4 across the x wrap
        queue_trial(0, 0, DRAW_MAX);           // zero change, draw ignored
        queue_trial(0, 0, DRAW_MAX);
        queue_trial(1, 0, DRAW_MAX);           // -4
        queue_trial(32, 32, 0);
        queue_trial(32, 32, DRAW_MAX);         // -8 flips back
        queue_trial(40, 40, DRAW_MAX);         // +8 rejected
        queue_trial(40, 40, 23);               // one above threshold
        queue_trial(40, 40, 22);
        queue_trial(63, 63, 1201);
        queue_trial(63, 63, 0);
        queue_trial(0, 63, 0);
        queue_trial(63, 0, DRAW_MAX);
        queue_trial(0, 1, 21);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_threshold(CFG_THR_FOUR, four_set[ph]);
            write_threshold(CFG_THR_EIGHT, eight_set[ph]);
            for (int n = 0; n < PHASE_TRIALS; n++)
                pending_trials.push_back(random_trial());
            wait_drained();
        end

        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("tb_ising_metropolis_spin_update_core passed");
        else
            $display("tb_ising_metropolis_spin_update_core failed");
        $finish;
    end

endmodule

// ----- ising_metropolis_spin_update_core.f -----
hw/rtl/isu_pkg.sv
hw/rtl/isu_ram.sv
hw/rtl/isu_ctrl.sv
hw/rtl/isu_dp.sv
hw/rtl/ising_metropolis_spin_update_core.sv
hw/rtl/isu_checker.sv
sim/tb_ising_metropolis_spin_update_core.sv
